[rtl/msb_first_bit_reader_unit_macros.svh]
// Assertion macros for the MSB-first bit reader.
// Used by the port checker that is bound to the top level.
`ifndef MSB_FIRST_BIT_READER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_READER_UNIT_MACROS_SVH

// Property must hold on every rising edge outside of reset.
`define MBR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside of reset.
`define MBR_NEVER(lbl, clk, rst, expr, msg) \
   `MBR_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

[rtl/mbr_pkg.sv]
// Shared types, codes and constants of the MSB-first bit reader.
// No dependencies; imported by every RTL module and the checker.
package mbr_pkg;

   // Default sizes, handed down from the top level parameters
   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int MAX_READ_BITS_DEF = 32;

   // Fixed field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 8;
   localparam int FUNC_W  = 3;
   localparam int STAT_W  = 3;
   localparam int VALUE_W = 32;
   localparam int TOTAL_W = 64;

   // Command queue between front and back (power of two)
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_END   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SKIP  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ALIGN = 3'd4;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_SHORT    = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADCOUNT = 3'd2;
   localparam logic [STAT_W-1:0] ST_FAULT    = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

   // Decoded operation
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_END,
      OP_READ,
      OP_SKIP,
      OP_ALIGN,
      OP_NONE
   } op_type;

   // Back-end engine states
   typedef enum logic [0:0] {
      ENG_IDLE,
      ENG_LOAD
   } eng_state_type;

   // Classified request as it travels from front to back
   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  data;
      logic [COUNT_W-1:0] count;
      logic               err;
      logic               bad_count;
   } cmd_type;

endpackage

[rtl/mbr_front.sv]
// Front end of the bit reader: accepts requests, decodes the function code,
// checks the read count and queues the classified command. Uses mbr_pkg.
module mbr_front #(
   parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mbr_pkg::FUNC_W-1:0]   req_func,
   input  logic [mbr_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [mbr_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic                         req_source_error,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output mbr_pkg::cmd_type             cmd
);
   import mbr_pkg::*;

   cmd_type               cmd_q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   cmd_type               dec;
   logic                  push, pop;

   // Classify the incoming request
   always_comb begin
      dec.data      = req_data_byte;
      dec.count     = req_bit_count;
      dec.err       = req_source_error;
      dec.bad_count = (req_bit_count == '0) ||
                      (req_bit_count > COUNT_W'(MAX_READ_BITS));
      unique case (req_func)
         FUNC_PUSH:  dec.op = OP_PUSH;
         FUNC_END:   dec.op = OP_END;
         FUNC_READ:  dec.op = OP_READ;
         FUNC_SKIP:  dec.op = OP_SKIP;
         FUNC_ALIGN: dec.op = OP_ALIGN;
         default:    dec.op = OP_NONE;
      endcase
   end

   // Queue control
   assign req_ready = (cnt_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

[rtl/mbr_back.sv]
// Back end of the bit reader: byte queue memory, bit window, totals and the
// engine that carries out each command, plus the response register. Uses mbr_pkg.
module mbr_back #(
   parameter int QUEUE_DEPTH   = mbr_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  mbr_pkg::cmd_type             cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mbr_pkg::VALUE_W-1:0]  rsp_value,
   output logic [mbr_pkg::STAT_W-1:0]   rsp_status,
   output logic                         rsp_at_end,
   output logic                         rsp_error_seen,
   output logic [mbr_pkg::TOTAL_W-1:0]  rsp_bits_read_total,
   output logic [mbr_pkg::TOTAL_W-1:0]  rsp_bytes_read_total
);
   import mbr_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int WIN_W   = MAX_READ_BITS + BYTE_W;
   localparam int WFILL_W = $clog2(WIN_W + 1);
   localparam int CHUNK_W = $clog2(MAX_READ_BITS + 1);

   localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(QUEUE_DEPTH);
   localparam logic [CHUNK_W-1:0] CHUNK_MAX = CHUNK_W'(MAX_READ_BITS);

   // Engine state
   eng_state_type       state_ff, state_in;
   op_type              op_ff, op_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;

   // Byte queue
   logic [BYTE_W-1:0]   byte_mem [QUEUE_DEPTH];
   logic [BYTE_W-1:0]   rd_byte_ff;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [FILL_W-1:0]   qfill_ff, qfill_in;
   logic                mem_we;

   // Bit window, totals, flags
   logic [WIN_W-1:0]    window_ff, window_in;
   logic [WFILL_W-1:0]  wfill_ff, wfill_in;
   logic [TOTAL_W-1:0]  tbits_ff, tbits_in;
   logic [TOTAL_W-1:0]  tbytes_ff, tbytes_in;
   logic                end_ff, end_in;
   logic                fault_ff, fault_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff;
   logic [STAT_W-1:0]   status_ff;
   logic                at_end_ff;
   logic                err_ff;
   logic [TOTAL_W-1:0]  bits_out_ff;
   logic [TOTAL_W-1:0]  bytes_out_ff;

   // Datapath helpers
   logic                out_free;
   logic [CHUNK_W-1:0]  chunk;
   logic                have_bits;
   logic                last_chunk;
   logic [WFILL_W-1:0]  fill_left;
   logic [WIN_W-1:0]    mask;
   logic [WIN_W-1:0]    extracted;
   logic [COUNT_W-1:0]  align_cnt;
   logic                finish;
   logic [VALUE_W-1:0]  res_value;
   logic [STAT_W-1:0]   res_status;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign chunk      = (rem_ff > COUNT_W'(MAX_READ_BITS)) ? CHUNK_MAX : rem_ff[CHUNK_W-1:0];
   assign have_bits  = (wfill_ff >= WFILL_W'(chunk));
   assign last_chunk = (op_ff == OP_READ) || (rem_ff <= COUNT_W'(MAX_READ_BITS));
   assign fill_left  = wfill_ff - WFILL_W'(chunk);
   assign mask       = ~({WIN_W{1'b1}} << chunk);
   assign extracted  = (window_ff >> fill_left) & mask;
   assign align_cnt  = COUNT_W'(wfill_ff[2:0]);

   // Engine state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Engine next state and datapath updates
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      rem_in     = rem_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      qfill_in   = qfill_ff;
      window_in  = window_ff;
      wfill_in   = wfill_ff;
      tbits_in   = tbits_ff;
      tbytes_in  = tbytes_ff;
      end_in     = end_ff;
      fault_in   = fault_ff;
      cmd_ready  = 1'b0;
      mem_we     = 1'b0;
      finish     = 1'b0;
      res_value  = '0;
      res_status = ST_OK;
      unique case (state_ff)
         ENG_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               op_in     = cmd.op;
               unique case (cmd.op)
                  OP_PUSH: begin
                     finish = 1'b1;
                     if (qfill_ff == FILL_FULL) begin
                        res_status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        tail_in   = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
                        qfill_in  = qfill_ff + FILL_W'(1);
                        tbytes_in = tbytes_ff + TOTAL_W'(1);
                     end
                  end
                  OP_END: begin
                     finish = 1'b1;
                     end_in = 1'b1;
                     if (cmd.err) begin
                        fault_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (cmd.bad_count) begin
                        finish     = 1'b1;
                        res_status = ST_BADCOUNT;
                     end else if (fault_ff) begin
                        finish     = 1'b1;
                        res_status = ST_FAULT;
                     end else begin
                        rem_in   = cmd.count;
                        state_in = ENG_LOAD;
                     end
                  end
                  OP_SKIP: begin
                     if (cmd.count == '0) begin
                        finish = 1'b1;
                     end else if (fault_ff) begin
                        finish     = 1'b1;
                        res_status = ST_FAULT;
                     end else begin
                        rem_in   = cmd.count;
                        state_in = ENG_LOAD;
                     end
                  end
                  OP_ALIGN: begin
                     if (align_cnt == '0) begin
                        finish = 1'b1;
                     end else if (fault_ff) begin
                        finish     = 1'b1;
                        res_status = ST_FAULT;
                     end else begin
                        rem_in   = align_cnt;
                        state_in = ENG_LOAD;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ENG_LOAD: begin
            if (have_bits) begin
               // Enough bits in the window: consume one chunk
               if (!last_chunk || out_free) begin
                  wfill_in = fill_left;
                  tbits_in = tbits_ff + TOTAL_W'(chunk);
                  rem_in   = rem_ff - COUNT_W'(chunk);
                  if (last_chunk) begin
                     finish   = 1'b1;
                     state_in = ENG_IDLE;
                     if (op_ff == OP_READ) begin
                        res_value = VALUE_W'(extracted[MAX_READ_BITS-1:0]);
                     end
                  end
               end
            end else if (qfill_ff == '0) begin
               // Source ran dry; bytes already moved and chunks dropped stay
               if (out_free) begin
                  finish     = 1'b1;
                  res_status = ST_SHORT;
                  state_in   = ENG_IDLE;
               end
            end else begin
               // Refill one byte from the queue head
               window_in = {window_ff[WIN_W-BYTE_W-1:0], rd_byte_ff};
               wfill_in  = wfill_ff + WFILL_W'(BYTE_W);
               head_in   = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
               qfill_in  = qfill_ff - FILL_W'(1);
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // Response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         qfill_ff     <= '0;
         window_ff    <= '0;
         wfill_ff     <= '0;
         tbits_ff     <= '0;
         tbytes_ff    <= '0;
         end_ff       <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         qfill_ff     <= qfill_in;
         window_ff    <= window_in;
         wfill_ff     <= wfill_in;
         tbits_ff     <= tbits_in;
         tbytes_ff    <= tbytes_in;
         end_ff       <= end_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operation context and response payload
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rem_ff <= rem_in;
      if (finish) begin
         value_ff     <= res_value;
         status_ff    <= res_status;
         at_end_ff    <= end_in && (wfill_in == '0) && (qfill_in == '0);
         err_ff       <= fault_in;
         bits_out_ff  <= tbits_in;
         bytes_out_ff <= tbytes_in;
      end
   end

   // Byte queue memory; read port follows the next head, new data bypasses
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_mem[tail_ff] <= cmd.data;
      end
      if (mem_we && (tail_ff == head_in)) begin
         rd_byte_ff <= cmd.data;
      end else begin
         rd_byte_ff <= byte_mem[head_in];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_value            = value_ff;
   assign rsp_status           = status_ff;
   assign rsp_at_end           = at_end_ff;
   assign rsp_error_seen       = err_ff;
   assign rsp_bits_read_total  = bits_out_ff;
   assign rsp_bytes_read_total = bytes_out_ff;

endmodule

[rtl/msb_first_bit_reader_unit.sv]
// Push, end and rejected requests pass through the command queue and are answered from the
// response register; a read, skip or align also runs the engine, which consumes one chunk
// at a time (one for a read or align, up to 8 for a skip) and moves bytes into the window.
// Push, end and rejected requests are taken 1 per cycle while responses are taken; a read
// moves up to 4 bytes, a skip up to QUEUE_DEPTH, and no new command starts meanwhile.
// Reset (synchronous, active high) empties both queues and clears totals and flags.
module msb_first_bit_reader_unit #(
   parameter int QUEUE_DEPTH   = mbr_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_READ_BITS = mbr_pkg::MAX_READ_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mbr_pkg::FUNC_W-1:0]   req_func,
   input  logic [mbr_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [mbr_pkg::COUNT_W-1:0]  req_bit_count,
   input  logic                         req_source_error,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mbr_pkg::VALUE_W-1:0]  rsp_value,
   output logic [mbr_pkg::STAT_W-1:0]   rsp_status,
   output logic                         rsp_at_end,
   output logic                         rsp_error_seen,
   output logic [mbr_pkg::TOTAL_W-1:0]  rsp_bits_read_total,
   output logic [mbr_pkg::TOTAL_W-1:0]  rsp_bytes_read_total
);
   import mbr_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   // Request decode and command queue
   mbr_front #(
      .MAX_READ_BITS (MAX_READ_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_data_byte    (req_data_byte),
      .req_bit_count    (req_bit_count),
      .req_source_error (req_source_error),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   // Execution engine and response register
   mbr_back #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .MAX_READ_BITS (MAX_READ_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (cmd_valid),
      .cmd_ready            (cmd_ready),
      .cmd                  (cmd),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_value            (rsp_value),
      .rsp_status           (rsp_status),
      .rsp_at_end           (rsp_at_end),
      .rsp_error_seen       (rsp_error_seen),
      .rsp_bits_read_total  (rsp_bits_read_total),
      .rsp_bytes_read_total (rsp_bytes_read_total)
   );

endmodule

[rtl/mbr_checker.sv]
// Port-level checker for the MSB-first bit reader, bound to the top level.
// Uses mbr_pkg and the assertion macros header.
`include "msb_first_bit_reader_unit_macros.svh"

module mbr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mbr_pkg::VALUE_W-1:0]  rsp_value,
   input logic [mbr_pkg::STAT_W-1:0]   rsp_status,
   input logic                         rsp_error_seen
);
   import mbr_pkg::*;

   // A stalled response keeps its value and status
   `MBR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status), "response changed while stalled")

   // Only a successful read carries a value
   `MBR_NEVER(a_value_zero, clock, reset, rsp_valid && (rsp_status != ST_OK) && (rsp_value != '0), "nonzero value on failed request")

   // Source error flag is sticky across responses
   `MBR_ASSERT(a_err_sticky, clock, reset, rsp_valid && rsp_ready && rsp_error_seen |=> !rsp_valid || rsp_error_seen, "error flag cleared")

   // Reset leaves no response pending
   `MBR_ASSERT(a_reset_idle, clock, 1'b0, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind msb_first_bit_reader_unit mbr_checker u_mbr_checker (.*);
